### hw/rtl/odq_pkg.sv
// ----------------------------------------------------------------------------
// odq_pkg
// Shared types and constants of the optical detect qualifier.
// ----------------------------------------------------------------------------
package odq_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRESHOLD   = 3'd0,
        CFG_INVERTED    = 3'd1,
        CFG_WINDOW_VOTE = 3'd2,
        CFG_WINDOW_LEN  = 3'd3,
        CFG_HOLDOFF_LEN = 3'd4
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam int RST_THRESHOLD   = 512;
    localparam int RST_WINDOW_LEN  = 64;
    localparam int RST_HOLDOFF_LEN = 1000;

    // Status flags of one result
    typedef struct packed {
        logic detected;
        logic changed;
        logic holdoff_active;
        logic window_done;
        logic raw_detect;
    } t_flags;

endpackage

### hw/rtl/optical_detect_qualifier.sv
// ----------------------------------------------------------------------------
// optical_detect_qualifier
// Path: an accepted sample is written into the queue, then taken into the result register.
// Throughput: one sample per cycle, sustained while the result side takes results.
// The front stalls only when the two-entry queue is full.
// Reset (synchronous, active low) clears state and counters, loads register defaults.
// ----------------------------------------------------------------------------
module optical_detect_qualifier #(
    parameter int ADC_BITS     = 10,
    parameter int WINDOW_BITS  = 12,
    parameter int HOLDOFF_BITS = 16,
    parameter int CFG_W        = (ADC_BITS > WINDOW_BITS)
                                 ? ((ADC_BITS > HOLDOFF_BITS) ? ADC_BITS : HOLDOFF_BITS)
                                 : ((WINDOW_BITS > HOLDOFF_BITS) ? WINDOW_BITS : HOLDOFF_BITS)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [odq_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]                  i_cfg_data,
    // Sample channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ADC_BITS-1:0]               i_sample,
    // Result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_detected,
    output logic                              o_changed,
    output logic                              o_holdoff_active,
    output logic                              o_window_done,
    output logic                              o_raw_detect,
    output logic [ADC_BITS-1:0]               o_conditioned_level
);
    import odq_pkg::*;

    localparam int Q_W = ADC_BITS + 1;

    // Configuration registers
    logic [ADC_BITS-1:0]     r_threshold;
    logic                    r_inverted;
    logic                    r_use_window_vote;
    logic [WINDOW_BITS-1:0]  r_window_len;
    logic [HOLDOFF_BITS-1:0] r_holdoff_len;

    // Front to queue
    logic                    push;
    logic [ADC_BITS-1:0]     f_level;
    logic                    f_raw;

    // Queue to back
    logic                    q_full;
    logic                    q_valid;
    logic [Q_W-1:0]          q_data;
    logic                    pop;

    t_flags                  flags;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold       <= ADC_BITS'(RST_THRESHOLD);
            r_inverted        <= 1'b0;
            r_use_window_vote <= 1'b0;
            r_window_len      <= WINDOW_BITS'(RST_WINDOW_LEN);
            r_holdoff_len     <= HOLDOFF_BITS'(RST_HOLDOFF_LEN);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD:   r_threshold       <= i_cfg_data[ADC_BITS-1:0];
                CFG_INVERTED:    r_inverted        <= i_cfg_data[0];
                CFG_WINDOW_VOTE: r_use_window_vote <= i_cfg_data[0];
                CFG_WINDOW_LEN:  r_window_len      <= i_cfg_data[WINDOW_BITS-1:0];
                CFG_HOLDOFF_LEN: r_holdoff_len     <= i_cfg_data[HOLDOFF_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Front: condition the sample and classify it against the threshold
    odq_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .i_sample    (i_sample),
        .i_threshold (r_threshold),
        .i_inverted  (r_inverted),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_level     (f_level),
        .o_raw       (f_raw)
    );

    // Queue: hold classified requests until the back end takes them
    odq_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_raw, f_level}),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // Back: hold-off, direct or window vote, and the result register
    odq_back #(
        .ADC_BITS     (ADC_BITS),
        .WINDOW_BITS  (WINDOW_BITS),
        .HOLDOFF_BITS (HOLDOFF_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_raw             (q_data[Q_W-1]),
        .i_level           (q_data[ADC_BITS-1:0]),
        .i_use_window_vote (r_use_window_vote),
        .i_window_len      (r_window_len),
        .i_holdoff_len     (r_holdoff_len),
        .i_out_stall       (i_out_stall),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .o_flags           (flags),
        .o_level           (o_conditioned_level)
    );

    assign o_detected       = flags.detected;
    assign o_changed        = flags.changed;
    assign o_holdoff_active = flags.holdoff_active;
    assign o_window_done    = flags.window_done;
    assign o_raw_detect     = flags.raw_detect;

endmodule

### hw/rtl/odq_front.sv
// ----------------------------------------------------------------------------
// odq_front
// Accepts samples, conditions and classifies them, and pushes them to the queue.
// ----------------------------------------------------------------------------
module odq_front #(
    parameter int ADC_BITS = 10
) (
    input  logic                i_in_valid,
    input  logic [ADC_BITS-1:0] i_sample,
    input  logic [ADC_BITS-1:0] i_threshold,
    input  logic                i_inverted,
    input  logic                i_q_full,
    output logic                o_in_stall,
    output logic                o_push,
    output logic [ADC_BITS-1:0] o_level,
    output logic                o_raw
);
    import odq_pkg::*;

    // Invert as full scale minus sample, i.e. a bitwise complement
    assign o_level    = i_inverted ? ~i_sample : i_sample;
    assign o_raw      = (o_level < i_threshold);
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid & ~i_q_full;

endmodule

### hw/rtl/odq_queue.sv
// ----------------------------------------------------------------------------
// odq_queue
// Two-entry queue between the classifying front and the state back end.
// ----------------------------------------------------------------------------
module odq_queue #(
    parameter int WIDTH = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import odq_pkg::*;

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             n_wr_ptr;
    logic             n_rd_ptr;
    logic [1:0]       n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hw/rtl/odq_back.sv
// ----------------------------------------------------------------------------
// odq_back
// Hold-off, direct and window-vote state update, with the result register.
// ----------------------------------------------------------------------------
module odq_back #(
    parameter int ADC_BITS     = 10,
    parameter int WINDOW_BITS  = 12,
    parameter int HOLDOFF_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  logic                    i_raw,
    input  logic [ADC_BITS-1:0]     i_level,
    input  logic                    i_use_window_vote,
    input  logic [WINDOW_BITS-1:0]  i_window_len,
    input  logic [HOLDOFF_BITS-1:0] i_holdoff_len,
    input  logic                    i_out_stall,
    output logic                    o_pop,
    output logic                    o_out_valid,
    output odq_pkg::t_flags         o_flags,
    output logic [ADC_BITS-1:0]     o_level
);
    import odq_pkg::*;

    logic                    r_state;
    logic [HOLDOFF_BITS-1:0] r_holdoff_left;
    logic [WINDOW_BITS-1:0]  r_window_count;
    logic [WINDOW_BITS-1:0]  r_agree_count;
    logic                    r_out_valid;
    t_flags                  r_flags;
    logic [ADC_BITS-1:0]     r_level;

    logic                    n_state;
    logic [HOLDOFF_BITS-1:0] n_holdoff_left;
    logic [WINDOW_BITS-1:0]  n_window_count;
    logic [WINDOW_BITS-1:0]  n_agree_count;
    t_flags                  n_flags;

    logic [WINDOW_BITS-1:0]  len;
    logic [WINDOW_BITS-1:0]  wc_inc;
    logic [WINDOW_BITS-1:0]  ac_inc;
    logic                    opposes;

    // Advance when the result register is free or being taken
    assign o_pop       = i_q_valid & (~r_out_valid | ~i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_flags     = r_flags;
    assign o_level     = r_level;

    always_comb begin
        len     = (i_window_len == '0) ? WINDOW_BITS'(1) : i_window_len;
        opposes = (i_raw != r_state);
        wc_inc  = r_window_count + WINDOW_BITS'(1);
        ac_inc  = r_agree_count + WINDOW_BITS'(opposes);

        n_state        = r_state;
        n_holdoff_left = r_holdoff_left;
        n_window_count = r_window_count;
        n_agree_count  = r_agree_count;
        n_flags        = '0;
        n_flags.raw_detect = i_raw;

        if (r_holdoff_left != '0) begin
            n_holdoff_left         = r_holdoff_left - HOLDOFF_BITS'(1);
            n_flags.holdoff_active = 1'b1;
        end else if (!i_use_window_vote) begin
            n_window_count = '0;
            n_agree_count  = '0;
            if (opposes) begin
                n_state         = ~r_state;
                n_holdoff_left  = i_holdoff_len;
                n_flags.changed = 1'b1;
            end
        end else begin
            n_window_count = wc_inc;
            n_agree_count  = ac_inc;
            if (wc_inc >= len) begin
                n_flags.window_done = 1'b1;
                n_window_count      = '0;
                n_agree_count       = '0;
                if (ac_inc == wc_inc) begin
                    n_state         = ~r_state;
                    n_holdoff_left  = i_holdoff_len;
                    n_flags.changed = 1'b1;
                end
            end
        end
        n_flags.detected = n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= 1'b0;
            r_holdoff_left <= '0;
            r_window_count <= '0;
            r_agree_count  <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_state        <= n_state;
                r_holdoff_left <= n_holdoff_left;
                r_window_count <= n_window_count;
                r_agree_count  <= n_agree_count;
                r_out_valid    <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_flags <= n_flags;
            r_level <= i_level;
        end
    end

    // The state only moves when a request is taken from the queue
    a_state_on_pop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != $past(r_state)) |-> $past(o_pop))
        else $error("detected state changed without a request");

    // A sample in the hold-off neither flips the state nor closes a window
    a_hold_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && r_holdoff_left != '0) |=>
            (!r_flags.changed && !r_flags.window_done && r_flags.holdoff_active))
        else $error("hold-off sample acted on");

    // A reported change matches the stored state flipping
    a_change_flip : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && n_flags.changed) |=> (r_state != $past(r_state)))
        else $error("change flag without state flip");

    // The agree count never runs ahead of the window count
    a_agree_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_agree_count <= r_window_count)
        else $error("agree count exceeds window count");

endmodule

### verif/optical_detect_qualifier_test.sv
// ----------------------------------------------------------------------------
// optical_detect_qualifier_test
// Self-checking bench for the optical detect qualifier. A queue-fed driver
// offers ADC samples, an in-bench predictor works out each verdict as the
// request is taken, and a monitor compares every result field by field.
// Register settings change only while the block is idle; both sides stall
// at random, with one long receiver hold and one sender pause.
// ----------------------------------------------------------------------------
module optical_detect_qualifier_test;

    import odq_pkg::*;

    localparam int ADC_W   = 10;
    localparam int WIN_W   = 12;
    localparam int HOLD_W  = 16;
    localparam int CFG_W   = 16;
    localparam int ADC_MAX = (1 << ADC_W) - 1;

    // Index that no register answers to; writes to it must be dropped
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 3'd7;

    localparam int SETTLE_CYCLES      = 4;   // result latency plus margin
    localparam int STALL_BURST_CYCLES = 40;  // long receiver hold
    localparam int SEGMENT_COUNT      = 16;
    localparam int SEGMENT_SAMPLES    = 100;
    localparam int REPORT_LIMIT       = 100;

    // Expected verdict for one sample
    typedef struct packed {
        t_flags           flags;
        logic [ADC_W-1:0] level;
    } t_verdict;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0]        i_cfg_data  = '0;
    logic                    i_in_valid  = 1'b0;
    logic [ADC_W-1:0]        i_sample    = '0;
    logic                    i_out_stall = 1'b0;

    logic                    o_in_stall;
    logic                    o_out_valid;
    logic                    o_detected;
    logic                    o_changed;
    logic                    o_holdoff_active;
    logic                    o_window_done;
    logic                    o_raw_detect;
    logic [ADC_W-1:0]        o_conditioned_level;

    always #5 i_clk = ~i_clk;

    optical_detect_qualifier u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_sample            (i_sample),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_detected          (o_detected),
        .o_changed           (o_changed),
        .o_holdoff_active    (o_holdoff_active),
        .o_window_done       (o_window_done),
        .o_raw_detect        (o_raw_detect),
        .o_conditioned_level (o_conditioned_level)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    logic [ADC_W-1:0] pending_samples[$];   // requests not yet taken
    t_verdict         awaited_verdicts[$];  // verdicts not yet seen
    int unsigned      mismatch_count = 0;

    int unsigned send_idle_pct = 0;
    int unsigned rcv_idle_pct  = 0;
    logic        send_hold     = 1'b0;

    logic        stall_burst_req  = 1'b0;
    logic        stall_burst_done = 1'b0;
    int unsigned stall_burst_cnt  = 0;
    logic        rcv_blocking;

    // Predictor copy of the registers, at their reset values
    logic [ADC_W-1:0]  cur_threshold   = ADC_W'(RST_THRESHOLD);
    logic              cur_inverted    = 1'b0;
    logic              cur_window_vote = 1'b0;
    logic [WIN_W-1:0]  cur_window_len  = WIN_W'(RST_WINDOW_LEN);
    logic [HOLD_W-1:0] cur_holdoff_len = HOLD_W'(RST_HOLDOFF_LEN);

    // Predictor copy of the detector state
    logic              det_state     = 1'b0;
    logic [HOLD_W-1:0] holdoff_left  = '0;
    logic [WIN_W-1:0]  window_fill   = '0;
    logic [WIN_W-1:0]  window_agree  = '0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Flip the debounced state: restart the window and arm the hold-off
    function automatic void toggle_state();
        det_state    = ~det_state;
        holdoff_left = cur_holdoff_len;
        window_fill  = '0;
        window_agree = '0;
    endfunction

    function automatic t_verdict qualify_sample(logic [ADC_W-1:0] smp);
        t_verdict         v;
        logic [ADC_W-1:0] lvl;
        logic             raw;
        logic [WIN_W-1:0] len;
        // full scale minus sample is the bitwise complement at this width
        lvl     = cur_inverted ? ~smp : smp;
        raw     = (lvl < cur_threshold);
        v       = '0;
        v.level = lvl;
        v.flags.raw_detect = raw;
        if (holdoff_left != 0) begin
            // ignored sample: count down only, leave the window alone
            holdoff_left = holdoff_left - 1'b1;
            v.flags.holdoff_active = 1'b1;
        end else if (!cur_window_vote) begin
            window_fill  = '0;
            window_agree = '0;
            if (raw != det_state) begin
                toggle_state();
                v.flags.changed = 1'b1;
            end
        end else begin
            len = (cur_window_len == 0) ? WIN_W'(1) : cur_window_len;
            window_fill = window_fill + 1'b1;
            if (raw != det_state)
                window_agree = window_agree + 1'b1;
            // a shortened window closes as soon as the fill reaches it
            if (window_fill >= len) begin
                v.flags.window_done = 1'b1;
                if (window_agree == window_fill) begin
                    toggle_state();
                    v.flags.changed = 1'b1;
                end else begin
                    window_fill  = '0;
                    window_agree = '0;
                end
            end
        end
        v.flags.detected = det_state;
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer queued requests, hold a stalled one unchanged
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // retire the request taken at this edge and predict its verdict
            if (i_in_valid && !o_in_stall) begin
                awaited_verdicts.push_back(qualify_sample(i_sample));
                void'(pending_samples.pop_front());
            end
            // the slot is free: offer the next request or idle
            if (!i_in_valid || !o_in_stall) begin
                if (pending_samples.size() != 0 && !send_hold
                        && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_sample   <= pending_samples[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Long receiver hold, counted here so the driver keeps offering
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_burst_cnt  <= 0;
            stall_burst_done <= 1'b0;
        end else if (stall_burst_req && !stall_burst_done) begin
            if (stall_burst_cnt == STALL_BURST_CYCLES - 1)
                stall_burst_done <= 1'b1;
            stall_burst_cnt <= stall_burst_cnt + 1;
        end
    end

    assign rcv_blocking = stall_burst_req && !stall_burst_done;

    // ------------------------------------------------------------------
    // Monitor: take results, compare with the oldest awaited verdict
    // ------------------------------------------------------------------
    task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatch_count < REPORT_LIMIT)
            $display("mismatch at %0t on %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_verdicts.size() == 0) begin
                    flag_mismatch("result with none awaited", o_conditioned_level, 0);
                end else begin
                    want = awaited_verdicts.pop_front();
                    if (o_detected !== want.flags.detected)
                        flag_mismatch("detected", o_detected, want.flags.detected);
                    if (o_changed !== want.flags.changed)
                        flag_mismatch("changed", o_changed, want.flags.changed);
                    if (o_holdoff_active !== want.flags.holdoff_active)
                        flag_mismatch("holdoff_active", o_holdoff_active,
                                      want.flags.holdoff_active);
                    if (o_window_done !== want.flags.window_done)
                        flag_mismatch("window_done", o_window_done, want.flags.window_done);
                    if (o_raw_detect !== want.flags.raw_detect)
                        flag_mismatch("raw_detect", o_raw_detect, want.flags.raw_detect);
                    if (o_conditioned_level !== want.level)
                        flag_mismatch("conditioned_level", o_conditioned_level, want.level);
                end
            end
            i_out_stall <= rcv_blocking || ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Write one register; the block must be idle. Mirror it in the predictor.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_THRESHOLD:   cur_threshold   = data[ADC_W-1:0];
            CFG_INVERTED:    cur_inverted    = data[0];
            CFG_WINDOW_VOTE: cur_window_vote = data[0];
            CFG_WINDOW_LEN:  cur_window_len  = data[WIN_W-1:0];
            CFG_HOLDOFF_LEN: cur_holdoff_len = data[HOLD_W-1:0];
            default: ;
        endcase
    endtask

    // Wait until every request is taken and every verdict seen, then let
    // the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        while (pending_samples.size() != 0 || i_in_valid || awaited_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Sample whose conditioned level lands on the chosen side of threshold
    function automatic logic [ADC_W-1:0] sample_of_class(bit want_raw);
        int unsigned lvl;
        if (want_raw && cur_threshold != 0)
            lvl = $urandom_range(int'(cur_threshold) - 1, 0);
        else if (!want_raw)
            lvl = $urandom_range(ADC_MAX, int'(cur_threshold));
        else
            lvl = $urandom_range(ADC_MAX, 0);
        return cur_inverted ? ADC_W'(ADC_MAX - lvl) : ADC_W'(lvl);
    endfunction

    // Pick a fresh register setting, with junk above each register's width
    task automatic shuffle_settings();
        logic [CFG_W-1:0] data;
        data = CFG_W'($urandom);
        case ($urandom_range(7))
            0:       data[ADC_W-1:0] = '0;
            1:       data[ADC_W-1:0] = '1;
            default: ;
        endcase
        write_reg(CFG_THRESHOLD, data);
        write_reg(CFG_INVERTED, CFG_W'($urandom));
        // lean towards window mode, where the deeper behaviour lives
        data    = CFG_W'($urandom);
        data[0] = ($urandom_range(9) < 6);
        write_reg(CFG_WINDOW_VOTE, data);
        data = CFG_W'($urandom);
        case ($urandom_range(9))
            0:       data[WIN_W-1:0] = '0;
            1:       data[WIN_W-1:0] = WIN_W'($urandom_range(24, 9));
            default: data[WIN_W-1:0] = WIN_W'($urandom_range(8, 1));
        endcase
        write_reg(CFG_WINDOW_LEN, data);
        data = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(30, 7))
                                        : CFG_W'($urandom_range(6, 0));
        write_reg(CFG_HOLDOFF_LEN, data);
        if ($urandom_range(3) == 0)
            write_reg(CFG_IDX_SPARE, CFG_W'($urandom));
    endtask

    // Queue runs of same-side samples sized around the window, plus noise
    task automatic queue_segment(int unsigned count);
        int unsigned queued;
        int unsigned run_len;
        int unsigned span;
        bit          want_raw;
        @(negedge i_clk);
        queued = 0;
        span   = (cur_window_len == 0) ? 1 : int'(cur_window_len);
        while (queued < count) begin
            if ($urandom_range(9) == 0) begin
                pending_samples.push_back(ADC_W'($urandom));
                queued++;
            end else begin
                want_raw = $urandom_range(1);
                run_len  = $urandom_range(2 * span + 2, 1);
                repeat (run_len) pending_samples.push_back(sample_of_class(want_raw));
                queued += run_len;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: threshold at mid scale, direct mode, no detect
        @(negedge i_clk);
        pending_samples.push_back(10'd1023);
        pending_samples.push_back(10'd512);
        pending_samples.push_back(10'd600);
        settle();

        // No hold-off: each opposing sample flips at once; threshold edge
        write_reg(CFG_HOLDOFF_LEN, 16'd0);
        @(negedge i_clk);
        pending_samples.push_back(10'd511);
        pending_samples.push_back(10'd512);
        pending_samples.push_back(10'd0);
        pending_samples.push_back(10'd1023);
        settle();

        // Threshold zero never detects; inversion, junk above register widths
        write_reg(CFG_THRESHOLD, 16'hFC00);
        write_reg(CFG_INVERTED, 16'hFFFF);
        @(negedge i_clk);
        pending_samples.push_back(10'd0);
        pending_samples.push_back(10'd1023);
        settle();

        // Threshold at full scale, still inverted
        write_reg(CFG_THRESHOLD, 16'hFFFF);
        @(negedge i_clk);
        pending_samples.push_back(10'd0);
        pending_samples.push_back(10'd1023);
        settle();

        // Short hold-off: the samples after a flip are ignored
        write_reg(CFG_HOLDOFF_LEN, 16'd3);
        write_reg(CFG_INVERTED, 16'hFFFE);
        write_reg(CFG_THRESHOLD, 16'd512);
        @(negedge i_clk);
        pending_samples.push_back(10'd1000);
        repeat (4) pending_samples.push_back(10'd0);
        settle();

        // Window mode with a zero length, taken as one sample per window
        write_reg(CFG_WINDOW_VOTE, 16'd1);
        write_reg(CFG_WINDOW_LEN, 16'd0);
        write_reg(CFG_HOLDOFF_LEN, 16'd0);
        @(negedge i_clk);
        repeat (4) pending_samples.push_back(10'd1023);
        pending_samples.push_back(10'd0);
        settle();

        // Mixed window keeps the state; drop a write to an unused index
        write_reg(CFG_IDX_SPARE, 16'hFFFF);
        write_reg(CFG_WINDOW_LEN, 16'd2);
        @(negedge i_clk);
        pending_samples.push_back(10'd0);
        pending_samples.push_back(10'd1023);
        settle();

        // Random segments: sender mostly busy, then receiver mostly busy,
        // then neither idles
        for (int seg = 0; seg < SEGMENT_COUNT; seg++) begin
            if (seg == 0) begin
                @(posedge i_clk);
                send_idle_pct <= 8;
                rcv_idle_pct  <= 81;
            end else if (seg == 5) begin
                @(posedge i_clk);
                send_idle_pct <= 81;
                rcv_idle_pct  <= 8;
            end else if (seg == 10) begin
                @(posedge i_clk);
                send_idle_pct <= 0;
                rcv_idle_pct  <= 0;
            end
            shuffle_settings();
            queue_segment(SEGMENT_SAMPLES);

            if (seg == 11) begin
                // hold the receiver off so the block fills and stalls its input
                @(posedge i_clk);
                stall_burst_req <= 1'b1;
                @(negedge i_clk);
                while (!stall_burst_done) @(negedge i_clk);
            end else if (seg == 13) begin
                // pause the sender mid-stream until every verdict is in
                @(negedge i_clk);
                while (pending_samples.size() > SEGMENT_SAMPLES / 2) @(negedge i_clk);
                @(posedge i_clk);
                send_hold <= 1'b1;
                @(negedge i_clk);
                while (i_in_valid || awaited_verdicts.size() != 0) @(negedge i_clk);
                @(posedge i_clk);
                send_hold <= 1'b0;
            end
            settle();
        end

        // Widest window and longest hold-off; a part-filled window then
        // closes once its length is lowered below the fill
        write_reg(CFG_WINDOW_VOTE, 16'd1);
        write_reg(CFG_WINDOW_LEN, 16'hFFFF);
        write_reg(CFG_HOLDOFF_LEN, 16'hFFFF);
        @(negedge i_clk);
        repeat (30) pending_samples.push_back(ADC_W'($urandom));
        settle();
        write_reg(CFG_WINDOW_LEN, 16'd5);
        @(negedge i_clk);
        pending_samples.push_back(ADC_W'($urandom));
        repeat (5) pending_samples.push_back(sample_of_class(~det_state));
        repeat (10) pending_samples.push_back(ADC_W'($urandom));
        settle();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_verdicts.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
